>>> rtl/core/lsf_pkg.sv
// lsf_pkg: shared constants, types and the lfo table generator for the swept flanger
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package lsf_pkg;

	localparam int LSF_DELAY_DEPTH    = 2048;
	localparam int LSF_LFO_TABLE_BITS = 10;

	localparam int LSF_SAMPLE_W = 16;
	localparam int LSF_STEP_W   = 32;
	localparam int LSF_GAIN_W   = 17;
	localparam int LSF_LEN_W    = 12;
	localparam int LSF_CFG_IDX_W = 2;
	localparam int LSF_LFO_W    = 17;
	localparam int LSF_MAC_A_W  = 18;

	localparam logic [LSF_CFG_IDX_W-1:0] REG_LFO_STEP  = 2'd0;
	localparam logic [LSF_CFG_IDX_W-1:0] REG_WET_GAIN  = 2'd1;
	localparam logic [LSF_CFG_IDX_W-1:0] REG_DELAY_LEN = 2'd2;

	localparam logic [LSF_STEP_W-1:0] LSF_STEP_RST = 32'd89478;
	localparam logic [LSF_GAIN_W-1:0] LSF_GAIN_RST = 17'd32768;
	localparam logic [LSF_LEN_W-1:0]  LSF_LEN_RST  = 12'd2048;
	localparam logic [LSF_GAIN_W-1:0] LSF_GAIN_ONE = 17'd65536;

	// (2n+1)(2n+2) for the cosine series terms
	localparam logic [8:0] LFO_TAYLOR_DIV [10] = '{
		9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380
	};
	localparam logic [63:0] PI_Q44  = 64'h0000_3243_F6A8_885A;
	localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;

	typedef struct packed {
		logic en;
		logic accumulate;
	} mac_ctrl_t;

	// cos(2*pi*k/T) in q30 for k in the first quadrant
	function automatic logic signed [63:0] lsf_cos_quadrant(input int unsigned k,
		input int unsigned tb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] acc;
		x = ((PI_Q44 * 64'd2 * 64'(k)) >> tb) >> 14;
		x2 = (x * x) >> 30;
		term = ONE_Q30;
		acc = $signed(ONE_Q30);
		for (int n = 0; n < 10; n++) begin
			term = (term * x2) >> 30;
			term = term / 64'(LFO_TAYLOR_DIV[n]);
			if ((n % 2) == 1)
				acc = acc + $signed(term);
			else
				acc = acc - $signed(term);
		end
		return acc;
	endfunction

	// entry k of the raised cosine table, 0.5-0.5cos in q1.16
	function automatic logic [LSF_LFO_W-1:0] lsf_lfo_entry(input int unsigned k,
		input int unsigned tb);
		int unsigned tsize;
		int unsigned m;
		logic signed [63:0] c;
		logic signed [63:0] v;
		tsize = 32'd1 << tb;
		m = (k > tsize / 2) ? tsize - k : k;
		if (m > tsize / 4)
			c = -lsf_cos_quadrant(tsize / 2 - m, tb);
		else
			c = lsf_cos_quadrant(m, tb);
		if (c > $signed(ONE_Q30))
			c = $signed(ONE_Q30);
		if (c < -$signed(ONE_Q30))
			c = -$signed(ONE_Q30);
		v = ($signed(ONE_Q30) - c + 64'sd16384) >>> 15;
		return v[LSF_LFO_W-1:0];
	endfunction

endpackage

>>> rtl/core/lfo_swept_flanger.sv
// lfo_swept_flanger: top level, sequencer around the shared mac, lfo table and delay line
// depends on lsf_pkg, lsf_lfo_rom, lsf_delay_mem and lsf_mac
`timescale 1ns / 1ps

// Each sample accepted on the s_ side produces one mixed sample on the m_ side. A sequencer
// steps through table lookup, delay offset, read position, delay read and the two mix
// products, and all three multiplications go through one shared multiply-accumulate unit,
// so a new sample is accepted only once the sequencer is through with the last one.
// s_tready is high only while the sequencer is idle. A finished result waits in the output
// register, and the next sample is accepted meanwhile; the sequencer only holds in its last
// step while an earlier result is still untaken. The delay line reads as zero where no
// sample has yet been written, so no clearing pass is needed after reset. Configuration
// writes on cfg_ are always accepted and must be issued only while no sample is in flight;
// index 0 is lfo_step, 1 wet_gain, 2 delay_len.
module lfo_swept_flanger #(
	parameter int DELAY_DEPTH    = lsf_pkg::LSF_DELAY_DEPTH,
	parameter int LFO_TABLE_BITS = lsf_pkg::LSF_LFO_TABLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lsf_pkg::LSF_SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lsf_pkg::LSF_SAMPLE_W-1:0]  m_tdata,   // [15:0] mixed_sample
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lsf_pkg::LSF_CFG_IDX_W-1:0] cfg_index,
	input  logic [lsf_pkg::LSF_STEP_W-1:0]    cfg_data
);
	import lsf_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int LW = $clog2(DELAY_DEPTH + 1);
	localparam int CW = (LW > LSF_LEN_W) ? LW : LSF_LEN_W;
	localparam int BW = ((AW > LSF_SAMPLE_W) ? AW : LSF_SAMPLE_W) + 1;
	localparam int PW = LSF_MAC_A_W + BW;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ROM  = 8'b0000_0010,
		S_OFF  = 8'b0000_0100,
		S_POS  = 8'b0000_1000,
		S_RD   = 8'b0001_0000,
		S_MW   = 8'b0010_0000,
		S_MD   = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t                  st_q;
	logic [LSF_STEP_W-1:0]   lfo_step_q;
	logic [LSF_GAIN_W-1:0]   wet_gain_q;
	logic [LSF_LEN_W-1:0]    delay_len_q;
	logic [LSF_STEP_W-1:0]   phase_q;
	logic [LSF_STEP_W-1:0]   sum_q;
	logic [LSF_SAMPLE_W-1:0] dry_q;
	logic [LW-1:0]           len_q;
	logic [AW-1:0]           wp_q;
	logic [LW-1:0]           fill_q;
	logic [AW-1:0]           pos_q;
	logic                    rd_ok_q;
	logic                    out_vld_q;
	logic [LSF_SAMPLE_W-1:0] out_q;

	logic                    in_acc;
	logic                    out_free;
	logic                    finish;
	logic [LSF_STEP_W:0]     phase_sum;
	logic [CW-1:0]           len_cfg;
	logic [CW-1:0]           len_clamp;
	logic [LW-1:0]           len_next;
	logic [LW-1:0]           len_m1;
	logic [LSF_GAIN_W-1:0]   gain_used;
	logic [LSF_LFO_W-1:0]    lfo;
	logic [LSF_SAMPLE_W-1:0] rdata;
	logic [LSF_SAMPLE_W-1:0] wet;
	logic [AW-1:0]           off;
	logic [AW:0]             pos_sum;
	logic [LW-1:0]           wp_inc;
	mac_ctrl_t               mac_ctrl;
	logic signed [LSF_MAC_A_W-1:0] mac_a;
	logic signed [BW-1:0]    mac_b;
	logic signed [PW-1:0]    mac_acc;

	assign s_tready  = (st_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_q;
	assign out_free  = !out_vld_q || m_tready;
	assign finish    = (st_q == S_DONE) && out_free;

	assign phase_sum = {1'b0, phase_q} + {1'b0, lfo_step_q};
	assign len_cfg   = CW'(delay_len_q);

	always_comb begin
		if (len_cfg < CW'(2))
			len_clamp = CW'(2);
		else if (len_cfg > CW'(DELAY_DEPTH))
			len_clamp = CW'(DELAY_DEPTH);
		else
			len_clamp = len_cfg;
	end

	assign len_next  = LW'(len_clamp);
	assign len_m1    = len_q - LW'(1);
	assign gain_used = (wet_gain_q > LSF_GAIN_ONE) ? LSF_GAIN_ONE : wet_gain_q;
	assign wet       = rd_ok_q ? rdata : '0;
	assign off       = mac_acc[16 +: AW];
	assign pos_sum   = {1'b0, wp_q} + {1'b0, off};
	assign wp_inc    = LW'(wp_q) + LW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_step_q  <= LSF_STEP_RST;
			wet_gain_q  <= LSF_GAIN_RST;
			delay_len_q <= LSF_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LFO_STEP:  lfo_step_q  <= cfg_data;
				REG_WET_GAIN:  wet_gain_q  <= cfg_data[LSF_GAIN_W-1:0];
				REG_DELAY_LEN: delay_len_q <= cfg_data[LSF_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			phase_q   <= '0;
			len_q     <= LW'(DELAY_DEPTH);
			wp_q      <= '0;
			fill_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (m_tready && !finish)
				out_vld_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						st_q  <= S_ROM;
						len_q <= len_next;
						if (LW'(wp_q) >= len_next)
							wp_q <= '0;
						if (phase_sum[LSF_STEP_W] && (phase_sum[LSF_STEP_W-1:0] != '0))
							phase_q <= '0;
						else
							phase_q <= phase_sum[LSF_STEP_W-1:0];
					end
				end
				S_ROM: st_q <= S_OFF;
				S_OFF: st_q <= S_POS;
				S_POS: st_q <= S_RD;
				S_RD:  st_q <= S_MW;
				S_MW:  st_q <= S_MD;
				S_MD:  st_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						st_q      <= S_IDLE;
						out_vld_q <= 1'b1;
						wp_q      <= (wp_inc >= len_q) ? '0 : AW'(wp_inc);
						if (wp_inc > fill_q)
							fill_q <= wp_inc;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_q <= phase_sum[LSF_STEP_W-1:0];
			dry_q <= s_tdata;
		end
		if (st_q == S_POS) begin
			if (pos_sum >= (AW+1)'(len_q))
				pos_q <= AW'(pos_sum - (AW+1)'(len_q));
			else
				pos_q <= AW'(pos_sum);
		end
		if (st_q == S_RD)
			rd_ok_q <= (LW'(pos_q) < fill_q);
		if (finish)
			out_q <= mac_acc[31:16];
	end

	always_comb begin
		mac_ctrl.en         = 1'b0;
		mac_ctrl.accumulate = 1'b0;
		mac_a               = '0;
		mac_b               = '0;
		unique case (st_q)
			S_OFF: begin
				mac_ctrl.en = 1'b1;
				mac_a       = LSF_MAC_A_W'(lfo);
				mac_b       = {{(BW-AW){1'b0}}, len_m1[AW-1:0]};
			end
			S_MW: begin
				mac_ctrl.en = 1'b1;
				mac_a       = LSF_MAC_A_W'(gain_used);
				mac_b       = {{(BW-LSF_SAMPLE_W){wet[LSF_SAMPLE_W-1]}}, wet};
			end
			S_MD: begin
				mac_ctrl.en         = 1'b1;
				mac_ctrl.accumulate = 1'b1;
				mac_a               = LSF_MAC_A_W'(LSF_GAIN_ONE - gain_used);
				mac_b               = {{(BW-LSF_SAMPLE_W){dry_q[LSF_SAMPLE_W-1]}}, dry_q};
			end
			default: ;
		endcase
	end

	lsf_lfo_rom #(
		.LFO_TABLE_BITS(LFO_TABLE_BITS)
	) u_lfo_rom (
		.clk  (clk),
		.addr (sum_q[LSF_STEP_W-1 -: LFO_TABLE_BITS]),
		.lfo  (lfo)
	);

	lsf_delay_mem #(
		.DELAY_DEPTH(DELAY_DEPTH),
		.AW         (AW)
	) u_delay_mem (
		.clk   (clk),
		.we    (finish),
		.waddr (wp_q),
		.wdata (dry_q),
		.raddr (pos_q),
		.rdata (rdata)
	);

	lsf_mac #(
		.BW(BW)
	) u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.a    (mac_a),
		.b    (mac_b),
		.acc  (mac_acc)
	);

	// write pointer stays inside the length in use while an item is in flight
	a_wp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> (LW'(wp_q) < len_q))
		else $error("write pointer beyond delay length");

	// wrapped read position lands inside the length in use
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_RD) |-> (LW'(pos_q) < len_q))
		else $error("read position beyond delay length");

	// table value never exceeds one in q1.16
	a_lfo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OFF) |-> (lfo <= LSF_GAIN_ONE))
		else $error("lfo table value out of range");

	// a waiting result is never overwritten by the next item
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready && (st_q == S_DONE)) |=> (st_q == S_DONE))
		else $error("sequencer left final step while result pending");

endmodule

>>> rtl/core/lsf_lfo_rom.sv
// lsf_lfo_rom: raised cosine lfo table with a registered read port
// depends on lsf_pkg for the table generator
`timescale 1ns / 1ps

module lsf_lfo_rom #(
	parameter int LFO_TABLE_BITS = lsf_pkg::LSF_LFO_TABLE_BITS
) (
	input  logic                          clk,
	input  logic [LFO_TABLE_BITS-1:0]     addr,
	output logic [lsf_pkg::LSF_LFO_W-1:0] lfo
);
	import lsf_pkg::*;

	localparam int TSIZE = 1 << LFO_TABLE_BITS;

	logic [LSF_LFO_W-1:0] rom [TSIZE];
	logic [LSF_LFO_W-1:0] lfo_q;

	for (genvar k = 0; k < TSIZE; k++) begin : g_rom
		assign rom[k] = lsf_lfo_entry(k, LFO_TABLE_BITS);
	end

	always_ff @(posedge clk) begin
		lfo_q <= rom[addr];
	end

	assign lfo = lfo_q;

endmodule

>>> rtl/core/lsf_delay_mem.sv
// lsf_delay_mem: delay line storage, one write port and one registered read port
// depends on lsf_pkg for the sample width
`timescale 1ns / 1ps

module lsf_delay_mem #(
	parameter int DELAY_DEPTH = lsf_pkg::LSF_DELAY_DEPTH,
	parameter int AW          = $clog2(DELAY_DEPTH)
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic [lsf_pkg::LSF_SAMPLE_W-1:0] wdata,
	input  logic [AW-1:0]                    raddr,
	output logic [lsf_pkg::LSF_SAMPLE_W-1:0] rdata
);
	import lsf_pkg::*;

	logic [LSF_SAMPLE_W-1:0] mem [DELAY_DEPTH];
	logic [LSF_SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/lsf_mac.sv
// lsf_mac: shared signed multiply-accumulate unit with a registered result
// depends on lsf_pkg for the control struct and operand width
`timescale 1ns / 1ps

module lsf_mac #(
	parameter int BW = 17
) (
	input  logic                                   clk,
	input  lsf_pkg::mac_ctrl_t                     ctrl,
	input  logic signed [lsf_pkg::LSF_MAC_A_W-1:0] a,
	input  logic signed [BW-1:0]                   b,
	output logic signed [lsf_pkg::LSF_MAC_A_W+BW-1:0] acc
);
	import lsf_pkg::*;

	localparam int PW = LSF_MAC_A_W + BW;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] acc_q;

	assign prod = PW'(a) * PW'(b);

	always_ff @(posedge clk) begin
		if (ctrl.en)
			acc_q <= ctrl.accumulate ? acc_q + prod : prod;
	end

	assign acc = acc_q;

endmodule

>>> verif/testbench.sv
// testbench: self-checking bench for lfo_swept_flanger, directed table then random phases
// depends on lsf_pkg and lfo_swept_flanger; checks every mixed sample against its own model or the table
`timescale 1ns / 1ps

module testbench;

	localparam int CURVE_BITS = lsf_pkg::LSF_LFO_TABLE_BITS;
	localparam int CURVE_SIZE = 1 << CURVE_BITS;
	localparam int LINE_DEPTH = lsf_pkg::LSF_DELAY_DEPTH;
	localparam logic [63:0] CURVE_PI = 64'h3243F6A8885A308D >> 16;
	localparam longint CURVE_ONE = longint'(1) << 30;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int TOTAL_ITEMS = 1050;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX = 10;

	typedef enum logic [1:0] {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [31:0] data;
		logic [15:0] smp;
		logic        typed;
		logic [15:0] want;
	} opening_row_t;

	localparam int OPENING_ROWS = 27;
	localparam opening_row_t OPENING [OPENING_ROWS] = '{
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h7FFF, 1'b1, 16'h3FFF},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 1'b1, 16'hC000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'hFFFF, 1'b1, 16'hFFFF},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h0000, 1'b1, 16'h0000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h0001, 1'b1, 16'h0000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h5555, 1'b1, 16'h2AAA},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'hAAAA, 1'b1, 16'hD555},
		// all wet, slot not yet written
		'{ROW_WRITE, lsf_pkg::REG_WET_GAIN, 32'h0001_0000, 16'h0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h1234, 1'b1, 16'h0000},
		// length shrunk under the pointer, reads restart at slot zero
		'{ROW_WRITE, lsf_pkg::REG_DELAY_LEN, 32'd2, 16'h0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h4321, 1'b1, 16'h7FFF},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h0F0F, 1'b1, 16'h8000},
		'{ROW_WRITE, lsf_pkg::REG_DELAY_LEN, 32'd0, 16'h0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h7FFF, 1'b0, 16'h0000},
		'{ROW_WRITE, lsf_pkg::REG_DELAY_LEN, 32'hFFFF_FFFF, 16'h0000, 1'b0, 16'h0000},
		'{ROW_WRITE, lsf_pkg::REG_WET_GAIN, 32'h0001_FFFF, 16'h0000, 1'b0, 16'h0000},
		'{ROW_WRITE, lsf_pkg::REG_LFO_STEP, 32'hFFFF_FFFF, 16'h0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h7FFF, 1'b0, 16'h0000},
		'{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, 16'h0000, 1'b0, 16'h0000},
		'{ROW_WRITE, lsf_pkg::REG_LFO_STEP, 32'h4000_0000, 16'h0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h0100, 1'b0, 16'h0000},
		// all dry, output equals input
		'{ROW_WRITE, lsf_pkg::REG_WET_GAIN, 32'd0, 16'h0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 1'b1, 16'h8000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'h7FFF, 1'b1, 16'h7FFF},
		'{ROW_WRITE, lsf_pkg::REG_LFO_STEP, 32'd0, 16'h0000, 1'b0, 16'h0000},
		'{ROW_SAMPLE, 2'd0, 32'd0, 16'hA5A5, 1'b1, 16'hA5A5}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [lsf_pkg::LSF_SAMPLE_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [lsf_pkg::LSF_SAMPLE_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [lsf_pkg::LSF_CFG_IDX_W-1:0] cfg_index;
	logic [lsf_pkg::LSF_STEP_W-1:0] cfg_data;

	// predictor state
	logic [16:0] sweep_curve [CURVE_SIZE];
	logic [15:0] line_mem [LINE_DEPTH];
	int unsigned wr_ptr;
	logic [31:0] sweep_phase;
	logic [31:0] cfg_step;
	logic [16:0] cfg_gain;
	logic [11:0] cfg_len;

	logic [15:0] pending_mix [$];
	int samples_in;
	int results_seen;
	int writes_done;
	int phases_run;
	int mismatches;
	int cycle_count;
	bit tx_calm;
	int rx_calm_left;

	lfo_swept_flanger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint quarter_cos(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint acc;
		x = ((CURVE_PI * 64'd2 * 64'(k)) >> CURVE_BITS) >> 14;
		x2 = (x * x) >> 30;
		term = 64'(CURVE_ONE);
		acc = CURVE_ONE;
		for (int n = 0; n < 10; n++) begin
			term = (term * x2) >> 30;
			term = term / 64'((2 * n + 1) * (2 * n + 2));
			if (n % 2 == 1)
				acc = acc + longint'(term);
			else
				acc = acc - longint'(term);
		end
		return acc;
	endfunction

	// one sample through the flanger: mixed output, then state update
	function automatic logic [15:0] mix_next(input logic [15:0] dry_bits);
		int unsigned len;
		int unsigned off;
		int unsigned pos;
		logic [32:0] sum;
		logic [16:0] lfo;
		logic [16:0] g;
		longint dry;
		longint wet;
		longint acc;
		len = (cfg_len < 2) ? 2 : ((cfg_len > LINE_DEPTH) ? LINE_DEPTH : 32'(cfg_len));
		if (wr_ptr >= len)
			wr_ptr = 0;
		sum = {1'b0, sweep_phase} + {1'b0, cfg_step};
		lfo = sweep_curve[sum[31 -: CURVE_BITS]];
		sweep_phase = (sum > 33'h1_0000_0000) ? 32'd0 : sum[31:0];
		off = (32'(lfo) * (len - 1)) >> 16;
		pos = wr_ptr + off;
		if (pos >= len)
			pos = pos - len;
		dry = longint'($signed(dry_bits));
		wet = longint'($signed(line_mem[pos]));
		g = (cfg_gain > lsf_pkg::LSF_GAIN_ONE) ? lsf_pkg::LSF_GAIN_ONE : cfg_gain;
		acc = longint'(g) * wet + (longint'(65536) - longint'(g)) * dry;
		acc = acc >>> 16;
		line_mem[wr_ptr] = dry_bits;
		wr_ptr = wr_ptr + 1;
		if (wr_ptr >= len)
			wr_ptr = 0;
		return acc[15:0];
	endfunction

	task automatic send_sample(input logic [15:0] smp, input logic typed,
		input logic [15:0] want);
		int unsigned gap;
		logic [15:0] guess;
		gap = tx_calm ? 0 : $urandom_range(0, 7);
		cfg_valid <= 1'b0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		do @(posedge clk); while (!s_tready);
		guess = mix_next(smp);
		pending_mix = {pending_mix, (typed ? want : guess)};
		samples_in++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		s_tvalid <= 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lsf_pkg::REG_LFO_STEP: cfg_step = data;
			lsf_pkg::REG_WET_GAIN: cfg_gain = data[16:0];
			lsf_pkg::REG_DELAY_LEN: cfg_len = data[11:0];
			default: ;
		endcase
		writes_done++;
	endtask

	initial begin : curve_build
		int unsigned m;
		longint c;
		longint e;
		for (int unsigned k = 0; k < CURVE_SIZE; k++) begin
			m = (k > CURVE_SIZE / 2) ? CURVE_SIZE - k : k;
			if (m > CURVE_SIZE / 4)
				c = -quarter_cos(CURVE_SIZE / 2 - m);
			else
				c = quarter_cos(m);
			if (c > CURVE_ONE)
				c = CURVE_ONE;
			if (c < -CURVE_ONE)
				c = -CURVE_ONE;
			e = (CURVE_ONE - c + 16384) >>> 15;
			sweep_curve[k] = e[16:0];
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_mix.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// output side, random stalls with calm stretches
	initial begin : result_taker
		int unsigned stall;
		m_tready = 1'b0;
		rx_calm_left = 0;
		@(posedge arst_n);
		forever begin
			if (rx_calm_left == 0 && $urandom_range(0, 15) == 0)
				rx_calm_left = $urandom_range(10, 40);
			stall = (rx_calm_left > 0) ? 0 : $urandom_range(0, 7);
			if (rx_calm_left > 0)
				rx_calm_left--;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_mix.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d: got %h with nothing pending", results_seen, m_tdata);
			end else begin
				want = pending_mix.pop_front();
				if (m_tdata !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("result %0d: mixed_sample expected %h, got %h",
							results_seen, want, m_tdata);
				end
			end
		end
	end

	initial begin : stimulus
		int n;
		logic [31:0] v;
		logic [15:0] smp;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_in = 0;
		writes_done = 0;
		phases_run = 0;
		tx_calm = 1'b0;
		cfg_step = lsf_pkg::LSF_STEP_RST;
		cfg_gain = lsf_pkg::LSF_GAIN_RST;
		cfg_len = lsf_pkg::LSF_LEN_RST;
		wr_ptr = 0;
		sweep_phase = '0;
		foreach (line_mem[i])
			line_mem[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[r]) begin
			if (OPENING[r].kind == ROW_WRITE)
				write_reg(OPENING[r].idx, OPENING[r].data);
			else
				send_sample(OPENING[r].smp, OPENING[r].typed, OPENING[r].want);
		end

		while (samples_in < TOTAL_ITEMS) begin
			phases_run++;
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 5))
					0: v = 32'd0;
					1: v = 32'hFFFF_FFFF;
					2: v = $urandom_range(1, 32'h0010_0000);
					3: v = 32'h8000_0000 | $urandom_range(0, 32'h00FF_FFFF);
					default: v = $urandom;
				endcase
				write_reg(lsf_pkg::REG_LFO_STEP, v);
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 4))
					0: v = 32'd0;
					1: v = 32'd65536;
					2: v = $urandom_range(65537, 131071);
					default: v = $urandom_range(0, 65536);
				endcase
				write_reg(lsf_pkg::REG_WET_GAIN, ($urandom & ~32'h1FFFF) | v);
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 6))
					0: v = $urandom_range(0, 3);
					1: v = 32'd2048;
					2: v = $urandom_range(2049, 4095);
					3: v = $urandom_range(2, 2048);
					default: v = $urandom_range(2, 64);
				endcase
				write_reg(lsf_pkg::REG_DELAY_LEN, ($urandom & ~32'hFFF) | v);
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, $urandom);
			tx_calm = ($urandom_range(0, 3) == 0);
			n = $urandom_range(10, 80);
			repeat (n) begin
				if (samples_in >= TOTAL_ITEMS)
					break;
				case ($urandom_range(0, 15))
					0: smp = 16'h8000;
					1: smp = 16'h7FFF;
					2: smp = 16'hFFFF;
					3: smp = 16'h0000;
					default: smp = $urandom;
				endcase
				send_sample(smp, 1'b0, 16'h0000);
			end
		end
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;

		while (pending_mix.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("%0d samples in %0d random phases after %0d table rows, %0d register writes",
			samples_in, phases_run, OPENING_ROWS, writes_done);
		$display("%0d mixed samples checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
